// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check a condition on every clock edge outside reset
`define ASSERT_ALWAYS(label, clock, reset_n, cond) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond)) \
        else $error("invariant check failed");

`endif

// ----- rtl/pva_pkg.sv -----
package pva_pkg;

    localparam int ROTATION_STAGES = 16;
    localparam int TABLE_STAGES    = 24;
    localparam int STAGES          = (ROTATION_STAGES > TABLE_STAGES) ? TABLE_STAGES
                                                                      : ROTATION_STAGES;
    localparam int STAGE_W         = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int TABLE_IDX_W     = 5;

    // Port field widths
    localparam int LEN_W     = 16;
    localparam int ANG_W     = 16;
    localparam int SUM_LEN_W = 17;
    localparam int DIR_W     = 16;

    // Internal widths: rotation components, rotation angle, vectoring components and angle
    localparam int ROT_W  = 27;
    localparam int ZR_W   = 28;
    localparam int VEC_W  = 29;
    localparam int ZV_W   = 30;
    localparam int ATAN_W = 26;

    // Angle units: input is 1/128 degree, internal is 2^-20 degree
    localparam int ANGLE_SHIFT = 13;
    localparam int ZFRAC_BITS  = 20;

    localparam logic [ANG_W-1:0] FULL_TURN_UNITS     = 16'd46080;
    localparam logic [ANG_W-1:0] QUARTER_UNITS       = 16'd11520;
    localparam logic [ANG_W-1:0] THREE_QUARTER_UNITS = 16'd34560;
    localparam logic [ANG_W-1:0] HALF_UNITS          = 16'd23040;

    localparam int HALF_TURN = 180;
    localparam logic signed [ZV_W-1:0] HALF_TURN_Z = ZV_W'(HALF_TURN * (1 << ZFRAC_BITS));

    localparam logic signed [DIR_W-1:0]  DIR_MAX    = 16'sd23040;
    localparam logic [SUM_LEN_W-1:0]     MAX_LENGTH = 17'd131070;

    // atan(2^-i) in degrees scaled by 2^20
    function automatic logic [ATAN_W-1:0] atan_z(input logic [TABLE_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 26'd47185920;
            5'd1:    v = 26'd27855475;
            5'd2:    v = 26'd14718068;
            5'd3:    v = 26'd7471121;
            5'd4:    v = 26'd3750058;
            5'd5:    v = 26'd1876857;
            5'd6:    v = 26'd938658;
            5'd7:    v = 26'd469357;
            5'd8:    v = 26'd234682;
            5'd9:    v = 26'd117342;
            5'd10:   v = 26'd58671;
            5'd11:   v = 26'd29335;
            5'd12:   v = 26'd14668;
            5'd13:   v = 26'd7334;
            5'd14:   v = 26'd3667;
            5'd15:   v = 26'd1833;
            5'd16:   v = 26'd917;
            5'd17:   v = 26'd458;
            5'd18:   v = 26'd229;
            5'd19:   v = 26'd115;
            5'd20:   v = 26'd57;
            5'd21:   v = 26'd29;
            5'd22:   v = 26'd14;
            5'd23:   v = 26'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Squared CORDIC gain in Q32, truncated step by step
    function automatic logic [63:0] gain_sq_q32();
        logic [63:0] g;
        g = 64'd1 << 32;
        for (int i = 0; i < STAGES; i++)
            g = g + (g >> (2 * i));
        return g;
    endfunction

    localparam logic [63:0] GAIN_SQ = gain_sq_q32();
    localparam int GAIN_W    = 34;
    localparam int GAIN_LO_W = 17;
    localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
    localparam logic [GAIN_W-1:0]    GAIN    = GAIN_SQ[GAIN_W-1:0];
    localparam logic [GAIN_LO_W-1:0] GAIN_LO = GAIN[GAIN_LO_W-1:0];
    localparam logic [GAIN_HI_W-1:0] GAIN_HI = GAIN[GAIN_W-1:GAIN_LO_W];

    // Length = round(x * 2^24 / G2): estimate by reciprocal, then one correction
    localparam int LEN_SHIFT       = 24;
    localparam int RECIP_SHIFT     = 27;
    localparam int RECIP_W         = 18;
    localparam logic [63:0] RECIP_FULL = (64'd1 << (RECIP_SHIFT + LEN_SHIFT)) / GAIN_SQ;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int XMAG_W = VEC_W - 1;
    localparam int PROD_W = XMAG_W + RECIP_W;
    localparam int Q_W    = 19;
    localparam int WIDE_W = 55;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ZR_W-1:0]  z;
    } rot_data_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ZV_W-1:0]  z;
        logic                    zero;
    } vec_data_t;

endpackage

// ----- rtl/pva_rot_cell.sv -----
module pva_rot_cell
    import pva_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [STAGE_W-1:0] stage,
    input  logic               in_valid,
    input  rot_data_t          in_a,
    input  rot_data_t          in_b,
    output logic               out_valid,
    output rot_data_t          out_a,
    output rot_data_t          out_b
);

    logic                   valid_reg;
    rot_data_t              a_reg, a_next;
    rot_data_t              b_reg, b_next;
    logic signed [ZR_W-1:0] step;

    function automatic rot_data_t rotate(input rot_data_t d, input logic [STAGE_W-1:0] sh,
                                         input logic signed [ZR_W-1:0] st);
        logic signed [ROT_W-1:0] dx;
        logic signed [ROT_W-1:0] dy;
        rot_data_t               r;
        dx = d.y >>> sh;
        dy = d.x >>> sh;
        r  = d;
        // drive z towards zero
        if (!d.z[ZR_W-1]) begin
            r.x = d.x - dx;
            r.y = d.y + dy;
            r.z = d.z - st;
        end
        else begin
            r.x = d.x + dx;
            r.y = d.y - dy;
            r.z = d.z + st;
        end
        return r;
    endfunction

    always_comb begin
        step   = $signed(ZR_W'(atan_z(TABLE_IDX_W'(stage))));
        a_next = rotate(in_a, stage, step);
        b_next = rotate(in_b, stage, step);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk) begin
        if (in_valid) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;

endmodule

// ----- rtl/pva_vec_cell.sv -----
`include "assert_macros.svh"

module pva_vec_cell
    import pva_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [STAGE_W-1:0] stage,
    input  logic               in_valid,
    input  vec_data_t          in_data,
    output logic               out_valid,
    output vec_data_t          out_data
);

    logic                    valid_reg;
    vec_data_t               data_reg, data_next;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [ZV_W-1:0]  step;

    always_comb begin
        dx        = in_data.y >>> stage;
        dy        = in_data.x >>> stage;
        step      = $signed(ZV_W'(atan_z(TABLE_IDX_W'(stage))));
        data_next = in_data;
        // drive y towards zero, accumulate the angle in z
        if (in_data.y[VEC_W-1]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - step;
        end
        else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk) begin
        if (in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // x starts non-negative and only grows through the vectoring row
    `ASSERT_ALWAYS(a_x_nonneg, clk, rst_n, !out_valid || !out_data.x[VEC_W-1])

endmodule

// ----- rtl/pva_scale.sv -----
`include "assert_macros.svh"

module pva_scale
    import pva_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  vec_data_t                   in_data,
    output logic                        done,
    output logic [SUM_LEN_W-1:0]        sum_length,
    output logic signed [DIR_W-1:0]     sum_direction
);

    localparam int DIRW_W = ZV_W - ANGLE_SHIFT + 1;

    // stage A: reciprocal estimate and direction rounding
    logic [XMAG_W-1:0]          x_mag;
    logic                       x_pos;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W:0]            prod_rnd;
    logic [Q_W-1:0]             est;
    logic signed [ZV_W:0]       z_rnd;
    logic signed [DIRW_W-1:0]   dir_wide;
    logic signed [DIR_W-1:0]    dir_next;

    logic                       a_valid_reg;
    logic [Q_W-1:0]             a_est_reg;
    logic [XMAG_W-1:0]          a_x_reg;
    logic                       a_keep_reg;
    logic signed [DIR_W-1:0]    a_dir_reg;

    // stage B: partial products of estimate times gain
    logic [Q_W+GAIN_LO_W-1:0]   lo_next;
    logic [Q_W+GAIN_HI_W-1:0]   hi_next;

    logic                       b_valid_reg;
    logic [Q_W+GAIN_LO_W-1:0]   b_lo_reg;
    logic [Q_W+GAIN_HI_W-1:0]   b_hi_reg;
    logic [Q_W-1:0]             b_est_reg;
    logic [XMAG_W-1:0]          b_x_reg;
    logic                       b_keep_reg;
    logic signed [DIR_W-1:0]    b_dir_reg;

    // stage C: remainder check and saturation
    logic [WIDE_W-1:0]          est_gain;
    logic [WIDE_W-1:0]          numer;
    logic [WIDE_W-1:0]          rem;
    logic [WIDE_W-1:0]          denom;
    logic [Q_W:0]               q;
    logic [SUM_LEN_W-1:0]       len_next;

    logic                       done_reg;
    logic [SUM_LEN_W-1:0]       sum_length_reg;
    logic signed [DIR_W-1:0]    sum_direction_reg;

    always_comb begin
        x_mag    = in_data.x[XMAG_W-1:0];
        x_pos    = !in_data.x[VEC_W-1] && (in_data.x != '0);
        prod     = x_mag * RECIP;
        prod_rnd = (PROD_W+1)'(prod) + (PROD_W+1)'(1 << (RECIP_SHIFT - 1));
        est      = Q_W'(prod_rnd >> RECIP_SHIFT);

        z_rnd    = (ZV_W+1)'(in_data.z) + (ZV_W+1)'(1 << (ANGLE_SHIFT - 1));
        dir_wide = DIRW_W'(z_rnd >>> ANGLE_SHIFT);
        if (in_data.zero)
            dir_next = '0;
        else if (dir_wide > DIR_MAX)
            dir_next = DIR_MAX;
        else if (dir_wide < -DIR_MAX)
            dir_next = -DIR_MAX;
        else
            dir_next = DIR_W'(dir_wide);
    end

    always_comb begin
        lo_next = a_est_reg * GAIN_LO;
        hi_next = a_est_reg * GAIN_HI;
    end

    always_comb begin
        est_gain = (WIDE_W'(b_hi_reg) << GAIN_LO_W) + WIDE_W'(b_lo_reg);
        numer    = (WIDE_W'(b_x_reg) << (LEN_SHIFT + 1)) + WIDE_W'(GAIN);
        denom    = WIDE_W'(GAIN) << 1;
        // estimate is never above the quotient and at most one below it
        rem      = numer - (est_gain << 1);
        q        = (Q_W+1)'(b_est_reg) + (Q_W+1)'(rem >= denom);
        if (!b_keep_reg)
            len_next = '0;
        else if (q > (Q_W+1)'(MAX_LENGTH))
            len_next = MAX_LENGTH;
        else
            len_next = SUM_LEN_W'(q);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            done_reg    <= b_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid) begin
            a_est_reg  <= est;
            a_x_reg    <= x_mag;
            a_keep_reg <= x_pos && !in_data.zero;
            a_dir_reg  <= dir_next;
        end
        if (a_valid_reg) begin
            b_lo_reg   <= lo_next;
            b_hi_reg   <= hi_next;
            b_est_reg  <= a_est_reg;
            b_x_reg    <= a_x_reg;
            b_keep_reg <= a_keep_reg;
            b_dir_reg  <= a_dir_reg;
        end
        if (b_valid_reg) begin
            sum_length_reg    <= len_next;
            sum_direction_reg <= b_dir_reg;
        end
    end

    assign done          = done_reg;
    assign sum_length    = sum_length_reg;
    assign sum_direction = sum_direction_reg;

    `ASSERT_IMPLY(a_done_follows_input, clk, rst_n, done, $past(in_valid, 3))
    `ASSERT_IMPLY(a_zero_sum_clean, clk, rst_n, done && $past(in_valid && in_data.zero, 3), sum_length == '0 && sum_direction == '0)

endmodule

// ----- rtl/polar_vector_adder_top.sv -----
// Polar vector adder: takes two vectors as (length Q8.8, direction in 1/128 degree) and
// returns the length (Q9.8, rounded, saturating at 131070) and atan2 direction
// (1/128 degree, -180 to +180 degrees) of their sum. A pair is taken on every clock
// with start high; busy never rises. Each result appears 2*STAGES+5 clocks later
// (37 clocks with 16 stages) for one clock, flagged by done, and must be taken then.
// The latency is set by two rows of CORDIC cells, one rotating both inputs and one
// vectoring the sum, plus an input register, the summing register and three
// registers for gain removal.
`include "assert_macros.svh"

module polar_vector_adder_top
    import pva_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [LEN_W-1:0]        magnitude_a,
    input  logic [ANG_W-1:0]        angle_a,
    input  logic [LEN_W-1:0]        magnitude_b,
    input  logic [ANG_W-1:0]        angle_b,
    output logic                    done,
    output logic [SUM_LEN_W-1:0]    sum_length,
    output logic signed [DIR_W-1:0] sum_direction
);

    localparam int LATENCY = 2 * STAGES + 5;

    logic                    in_valid_reg;
    rot_data_t               in_a_reg;
    rot_data_t               in_b_reg;

    logic                    rot_valid [0:STAGES];
    rot_data_t               rot_a     [0:STAGES];
    rot_data_t               rot_b     [0:STAGES];

    logic signed [VEC_W-1:0] sx;
    logic signed [VEC_W-1:0] sy;
    vec_data_t               sum_next;
    logic                    sum_valid_reg;
    vec_data_t               sum_reg;

    logic                    vec_valid [0:STAGES];
    vec_data_t               vec_data  [0:STAGES];

    // Fold the angle into -90..+90 degrees, negating the start vector where needed
    function automatic rot_data_t polar_start(input logic [LEN_W-1:0] len,
                                              input logic [ANG_W-1:0] ang);
        logic [ANG_W-1:0]        a;
        logic signed [ANG_W:0]   rel;
        logic signed [ROT_W-1:0] mag;
        rot_data_t               r;
        a   = (ang >= FULL_TURN_UNITS) ? ang - FULL_TURN_UNITS : ang;
        mag = $signed(ROT_W'({len, 8'd0}));
        if (a >= QUARTER_UNITS && a < THREE_QUARTER_UNITS) begin
            rel = $signed({1'b0, a}) - $signed({1'b0, HALF_UNITS});
            r.x = -mag;
        end
        else if (a >= THREE_QUARTER_UNITS) begin
            rel = $signed({1'b0, a}) - $signed({1'b0, FULL_TURN_UNITS});
            r.x = mag;
        end
        else begin
            rel = $signed({1'b0, a});
            r.x = mag;
        end
        r.y = '0;
        r.z = ZR_W'(rel) <<< ANGLE_SHIFT;
        return r;
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk) begin
        if (start && !busy) begin
            in_a_reg <= polar_start(magnitude_a, angle_a);
            in_b_reg <= polar_start(magnitude_b, angle_b);
        end
    end

    assign rot_valid[0] = in_valid_reg;
    assign rot_a[0]     = in_a_reg;
    assign rot_b[0]     = in_b_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        pva_rot_cell u_rot_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (STAGE_W'(i)),
            .in_valid  (rot_valid[i]),
            .in_a      (rot_a[i]),
            .in_b      (rot_b[i]),
            .out_valid (rot_valid[i+1]),
            .out_a     (rot_a[i+1]),
            .out_b     (rot_b[i+1])
        );
    end

    // Sum the components; flip a left-half sum into the right half and preload z
    always_comb begin
        sx            = VEC_W'(rot_a[STAGES].x) + VEC_W'(rot_b[STAGES].x);
        sy            = VEC_W'(rot_a[STAGES].y) + VEC_W'(rot_b[STAGES].y);
        sum_next.zero = (sx == '0) && (sy == '0);
        if (sx[VEC_W-1]) begin
            sum_next.x = -sx;
            sum_next.y = -sy;
            sum_next.z = sy[VEC_W-1] ? -HALF_TURN_Z : HALF_TURN_Z;
        end
        else begin
            sum_next.x = sx;
            sum_next.y = sy;
            sum_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else
            sum_valid_reg <= rot_valid[STAGES];
    end

    always_ff @(posedge clk) begin
        if (rot_valid[STAGES])
            sum_reg <= sum_next;
    end

    assign vec_valid[0] = sum_valid_reg;
    assign vec_data[0]  = sum_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_vec
        pva_vec_cell u_vec_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (STAGE_W'(i)),
            .in_valid  (vec_valid[i]),
            .in_data   (vec_data[i]),
            .out_valid (vec_valid[i+1]),
            .out_data  (vec_data[i+1])
        );
    end

    pva_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (vec_valid[STAGES]),
        .in_data       (vec_data[STAGES]),
        .done          (done),
        .sum_length    (sum_length),
        .sum_direction (sum_direction)
    );

    // each result comes from an earlier transfer taken with start high and busy low
    `ASSERT_IMPLY(a_fixed_latency, clk, rst_n, done, $past(start && !busy, LATENCY))

endmodule
